// ----- design/cpbft_pkg.sv -----
// Shared constants, command and status codes, and record types of the filter table.
package cpbft_pkg;

  localparam int DEF_MAX_FILTERS  = 8;
  localparam int DEF_NUM_CHANNELS = 2;
  localparam int FILTER_BYTES     = 8;
  localparam int BYTE_W           = 8;
  localparam int ID_BYTES         = 4;
  localparam int LEN_W            = 4;
  localparam int ID_W             = 32;
  localparam int BYTES_W          = FILTER_BYTES * BYTE_W;
  localparam int CMD_W            = 2;
  localparam int STATUS_W         = 2;
  localparam int QDEPTH           = 2;
  localparam int QPTR_W           = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QLVL_W           = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_NO_ID = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               kind;
    logic [BYTES_W-1:0] mask;
    logic [BYTES_W-1:0] pattern;
    logic [LEN_W-1:0]   len;
  } entry_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               ch_ok;
    logic               channel;
    logic               kind;
    logic [BYTES_W-1:0] mask;
    logic [BYTES_W-1:0] pattern;
    logic [LEN_W-1:0]   len;
    logic [ID_W-1:0]    target;
    logic [BYTES_W-1:0] view;
    logic [LEN_W-1:0]   vlen;
  } work_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              full;
    logic              empty;
  } q_stat_t;

endpackage

// ----- design/cpbft_ifs.sv -----
// Valid/ready channel interfaces for commands and results.
interface cpbft_in_if import cpbft_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic               channel;
  logic               filter_kind;
  logic [BYTES_W-1:0] mask_bytes;
  logic [LEN_W-1:0]   mask_length;
  logic [BYTES_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]   pattern_length;
  logic [ID_W-1:0]    target_filter;
  logic [ID_W-1:0]    frame_id;
  logic [BYTES_W-1:0] frame_data;
  logic [LEN_W-1:0]   frame_dlc;

  modport source (
    output valid, command, channel, filter_kind, mask_bytes, mask_length,
           pattern_bytes, pattern_length, target_filter, frame_id, frame_data,
           frame_dlc,
    input  ready
  );
  modport sink (
    input  valid, command, channel, filter_kind, mask_bytes, mask_length,
           pattern_bytes, pattern_length, target_filter, frame_id, frame_data,
           frame_dlc,
    output ready
  );
endinterface

interface cpbft_out_if import cpbft_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     assigned_id;
  logic                frame_passes;

  modport source (output valid, status, assigned_id, frame_passes, input ready);
  modport sink (input valid, status, assigned_id, frame_passes, output ready);
endinterface

// ----- design/cpbft_front.sv -----
// Front end: accept command beats, clip lengths, trim patterns and build the frame view.
module cpbft_front
  import cpbft_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic     rst_n,
  cpbft_in_if.sink in_if,
  input  q_stat_t  q_stat,
  output logic     push,
  output work_t    push_item
);

  function automatic logic [LEN_W-1:0] clip8(logic [LEN_W-1:0] v);
    return (v > LEN_W'(FILTER_BYTES)) ? LEN_W'(FILTER_BYTES) : v;
  endfunction

  logic [LEN_W-1:0]   mlen;
  logic [LEN_W-1:0]   plen;
  logic [BYTES_W-1:0] pat_kept;

  assign in_if.ready = rst_n && !q_stat.full;
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    mlen = clip8(in_if.mask_length);
    plen = clip8(in_if.pattern_length);
    if (plen > mlen) begin
      plen = mlen;
    end
    for (int b = 0; b < FILTER_BYTES; b++) begin
      pat_kept[BYTES_W-1-BYTE_W*b -: BYTE_W] =
        (LEN_W'(b) < plen) ? in_if.pattern_bytes[BYTES_W-1-BYTE_W*b -: BYTE_W] : '0;
    end
  end

  always_comb begin
    push_item.cmd     = cmd_t'(in_if.command);
    push_item.ch_ok   = (32'(in_if.channel) < NUM_CHANNELS);
    push_item.channel = in_if.channel;
    push_item.kind    = in_if.filter_kind;
    push_item.mask    = in_if.mask_bytes;
    push_item.pattern = pat_kept;
    push_item.len     = mlen;
    push_item.target  = in_if.target_filter;
    push_item.view    = {in_if.frame_id, in_if.frame_data[BYTES_W-1 -: BYTES_W-ID_W]};
    push_item.vlen    = LEN_W'(ID_BYTES) + clip8(in_if.frame_dlc);
  end

endmodule

// ----- design/cpbft_queue.sv -----
// Short command queue between the front end and the table sequencer.
module cpbft_queue
  import cpbft_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  work_t   push_item,
  input  logic    pop,
  output work_t   pop_item,
  output q_stat_t q_stat
);

  work_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0] level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + QLVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QLVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = slot_r[rd_ptr_r];
  assign q_stat.level = level_r;
  assign q_stat.full  = (level_r == QLVL_W'(QDEPTH));
  assign q_stat.empty = (level_r == '0);

endmodule

// ----- design/cpbft_back.sv -----
// Back end: table memory, per-channel counters and the command sequencer with result register.
module cpbft_back
  import cpbft_pkg::*;
#(
  parameter int MAX_FILTERS  = DEF_MAX_FILTERS,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  q_stat_t       q_stat,
  input  work_t         head,
  output logic          pop,
  cpbft_out_if.source   out_if
);

  localparam int TABLE_SIZE = MAX_FILTERS * NUM_CHANNELS;
  localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int SLOT_W     = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int CNT_W      = $clog2(MAX_FILTERS + 1);
  localparam int CH_IW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADD   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_MV_RD = 6'b001000,
    S_MV_WR = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  function automatic logic [ADDR_W-1:0] addr_of(logic ch, logic [SLOT_W-1:0] slot);
    return ADDR_W'(32'(ch) * MAX_FILTERS + 32'(slot));
  endfunction

  function automatic logic entry_match(entry_t e, logic [BYTES_W-1:0] view,
                                       logic [LEN_W-1:0] vlen);
    logic ok;
    ok = (vlen >= e.len);
    for (int b = 0; b < FILTER_BYTES; b++) begin
      if ((LEN_W'(b) < e.len) &&
          ((view[BYTES_W-1-BYTE_W*b -: BYTE_W] & e.mask[BYTES_W-1-BYTE_W*b -: BYTE_W]) !=
           (e.pattern[BYTES_W-1-BYTE_W*b -: BYTE_W] & e.mask[BYTES_W-1-BYTE_W*b -: BYTE_W])))
      begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  entry_t entry_mem [TABLE_SIZE];
  entry_t rd_q;

  state_t            state_r, state_nxt;
  work_t             cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r [NUM_CHANNELS];
  logic [CNT_W-1:0]  cnt_nxt [NUM_CHANNELS];
  logic [ID_W-1:0]   nid_r [NUM_CHANNELS];
  logic [ID_W-1:0]   nid_nxt [NUM_CHANNELS];
  logic [CNT_W-1:0]  ccnt_r, ccnt_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] ev_slot_r, ev_slot_nxt;
  logic              hit_r, hit_nxt;
  logic [SLOT_W-1:0] hit_slot_r, hit_slot_nxt;
  logic              blocked_r, blocked_nxt;
  logic              has_pass_r, has_pass_nxt;
  logic              pass_hit_r, pass_hit_nxt;
  status_t           status_r, status_nxt;
  logic [ID_W-1:0]   assigned_r, assigned_nxt;

  logic              ov_r, ov_nxt;
  status_t           ostatus_r;
  logic [ID_W-1:0]   oid_r;
  logic              opass_r;
  logic              load_out;

  logic [CH_IW-1:0]  hchi;
  logic [CH_IW-1:0]  chi;
  logic [CNT_W-1:0]  hcnt;
  logic [CNT_W-1:0]  last_cnt;
  logic              issue;
  logic              ev_match;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  assign hchi     = CH_IW'(head.channel);
  assign chi      = CH_IW'(cur_r.channel);
  assign hcnt     = head.ch_ok ? cnt_r[hchi] : '0;
  assign last_cnt = ccnt_r - CNT_W'(1);
  assign issue    = (state_r == S_SCAN) && (rd_idx_r != ccnt_r) && !hit_r;
  assign ev_match = entry_match(rd_q, cur_r.view, cur_r.vlen);
  assign load_out = (state_r == S_RESP) && (!ov_r || out_if.ready);

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    cnt_nxt      = cnt_r;
    nid_nxt      = nid_r;
    ccnt_nxt     = ccnt_r;
    rd_idx_nxt   = rd_idx_r;
    rd_vld_nxt   = 1'b0;
    ev_slot_nxt  = ev_slot_r;
    hit_nxt      = hit_r;
    hit_slot_nxt = hit_slot_r;
    blocked_nxt  = blocked_r;
    has_pass_nxt = has_pass_r;
    pass_hit_nxt = pass_hit_r;
    status_nxt   = status_r;
    assigned_nxt = assigned_r;
    pop          = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = addr_of(cur_r.channel, rd_idx_r[SLOT_W-1:0]);
    wr_en        = 1'b0;
    wr_addr      = addr_of(cur_r.channel, ccnt_r[SLOT_W-1:0]);
    wr_data      = rd_q;

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop          = 1'b1;
          cur_nxt      = head;
          ccnt_nxt     = hcnt;
          rd_idx_nxt   = '0;
          hit_nxt      = 1'b0;
          blocked_nxt  = 1'b0;
          has_pass_nxt = 1'b0;
          pass_hit_nxt = 1'b0;
          status_nxt   = STATUS_OK;
          assigned_nxt = '0;
          case (head.cmd)
            CMD_ADD: begin
              if (!head.ch_ok || (hcnt >= CNT_W'(MAX_FILTERS))) begin
                status_nxt = STATUS_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_ADD;
              end
            end
            CMD_STOP, CMD_CHECK: begin
              state_nxt = S_SCAN;
            end
            CMD_CLEAR: begin
              if (head.ch_ok) begin
                cnt_nxt[hchi] = '0;
              end
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_ADD: begin
        wr_en          = 1'b1;
        wr_data.id     = nid_r[chi];
        wr_data.kind   = cur_r.kind;
        wr_data.mask   = cur_r.mask;
        wr_data.pattern = cur_r.pattern;
        wr_data.len    = cur_r.len;
        cnt_nxt[chi]   = ccnt_r + CNT_W'(1);
        nid_nxt[chi]   = nid_r[chi] + ID_W'(1);
        assigned_nxt   = nid_r[chi];
        state_nxt      = S_RESP;
      end
      S_SCAN: begin
        rd_en       = issue;
        rd_vld_nxt  = issue;
        ev_slot_nxt = rd_idx_r[SLOT_W-1:0];
        rd_idx_nxt  = rd_idx_r + CNT_W'(issue);
        if (rd_vld_r && !hit_r) begin
          if (cur_r.cmd == CMD_STOP) begin
            if (rd_q.id == cur_r.target) begin
              hit_nxt      = 1'b1;
              hit_slot_nxt = ev_slot_r;
            end
          end else if (rd_q.kind) begin
            blocked_nxt = blocked_r | ev_match;
          end else begin
            has_pass_nxt = 1'b1;
            pass_hit_nxt = pass_hit_r | ev_match;
          end
        end
        if (((rd_idx_r == ccnt_r) || hit_r) && !rd_vld_r) begin
          if (cur_r.cmd == CMD_STOP) begin
            if (hit_r) begin
              state_nxt = S_MV_RD;
            end else begin
              status_nxt = STATUS_NO_ID;
              state_nxt  = S_RESP;
            end
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_MV_RD: begin
        rd_en     = 1'b1;
        rd_addr   = addr_of(cur_r.channel, last_cnt[SLOT_W-1:0]);
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        wr_en        = 1'b1;
        wr_addr      = addr_of(cur_r.channel, hit_slot_r);
        wr_data      = rd_q;
        cnt_nxt[chi] = last_cnt;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ov_nxt = load_out || (ov_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
      ov_r     <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cnt_r[c] <= '0;
        nid_r[c] <= ID_W'(1);
      end
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      ov_r     <= ov_nxt;
      cnt_r    <= cnt_nxt;
      nid_r    <= nid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    ccnt_r     <= ccnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    ev_slot_r  <= ev_slot_nxt;
    hit_r      <= hit_nxt;
    hit_slot_r <= hit_slot_nxt;
    blocked_r  <= blocked_nxt;
    has_pass_r <= has_pass_nxt;
    pass_hit_r <= pass_hit_nxt;
    status_r   <= status_nxt;
    assigned_r <= assigned_nxt;
    if (load_out) begin
      ostatus_r <= status_r;
      oid_r     <= assigned_r;
      opass_r   <= (cur_r.cmd == CMD_CHECK) && !blocked_r && (!has_pass_r || pass_hit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= entry_mem[rd_addr];
    end
  end

  assign out_if.valid        = ov_r;
  assign out_if.status       = ostatus_r;
  assign out_if.assigned_id  = oid_r;
  assign out_if.frame_passes = opass_r;

endmodule

// ----- design/can_pass_block_filter_table.sv -----
// Top level of the CAN pass/block filter table: front end, command queue and table sequencer.
// An add writes the new entry in S_ADD before S_RESP; clear and refused adds go straight to S_RESP.
// Stop and check walk the channel's entries through the table memory's one read port,
// one entry per cycle; a found stop then moves the last entry into its slot (S_MV_RD, S_MV_WR).
// Beats are taken while the two-entry queue has room; one command runs in the sequencer at a time.
// Reset sets every filter count to zero and every next id to one; the table memory is not cleared.
module can_pass_block_filter_table
  import cpbft_pkg::*;
#(
  parameter int MAX_FILTERS  = DEF_MAX_FILTERS,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  cpbft_in_if.sink    in_if,
  cpbft_out_if.source out_if
);

  q_stat_t q_stat;
  logic    push;
  work_t   push_item;
  logic    pop;
  work_t   head;

  cpbft_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_stat   (q_stat),
    .push     (push),
    .push_item(push_item)
  );

  cpbft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .pop_item (head),
    .q_stat   (q_stat)
  );

  cpbft_back #(
    .MAX_FILTERS (MAX_FILTERS),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .q_stat(q_stat),
    .head  (head),
    .pop   (pop),
    .out_if(out_if)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QLVL_W'(QDEPTH))
    else $error("command queue level above its depth");

  a_beat_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> (q_stat.level != '0))
    else $error("accepted beat did not land in the queue");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result offered right after reset");

endmodule

// ----- test/cpbft_checker.sv -----
// Checker for the filter table: predicts each command's answer and compares result beats.
module cpbft_checker
  import cpbft_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  cpbft_in_if   in_ch,
  cpbft_out_if  out_ch,
  output int    mismatches,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS  = DEF_MAX_FILTERS;
  localparam int LANES  = DEF_NUM_CHANNELS;
  localparam int VIEW_W = BYTE_W * (ID_BYTES + FILTER_BYTES);

  typedef struct packed {
    cmd_t               command;
    logic               channel;
    logic               filter_kind;
    logic [BYTES_W-1:0] mask_bytes;
    logic [LEN_W-1:0]   mask_length;
    logic [BYTES_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]   pattern_length;
    logic [ID_W-1:0]    target_filter;
    logic [ID_W-1:0]    frame_id;
    logic [BYTES_W-1:0] frame_data;
    logic [LEN_W-1:0]   frame_dlc;
  } beat_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] assigned_id;
    logic            frame_passes;
  } verdict_t;

  logic [ID_W-1:0]    slot_id    [LANES][SLOTS];
  logic               slot_block [LANES][SLOTS];
  logic [BYTES_W-1:0] slot_mask  [LANES][SLOTS];
  logic [BYTES_W-1:0] slot_pat   [LANES][SLOTS];
  int                 slot_len   [LANES][SLOTS];
  int                 slot_count [LANES];
  logic [ID_W-1:0]    id_next    [LANES];

  verdict_t awaited[$];
  int       error_tally;

  function automatic int clip_len(logic [LEN_W-1:0] v);
    return (v > FILTER_BYTES) ? FILTER_BYTES : int'(v);
  endfunction

  function automatic logic [BYTE_W-1:0] byte_at(logic [BYTES_W-1:0] w, int i);
    return w[BYTES_W-1-BYTE_W*i -: BYTE_W];
  endfunction

  function automatic logic slot_hits(int c, int s, logic [VIEW_W-1:0] view, int vlen);
    logic [BYTE_W-1:0] m;
    if (vlen < slot_len[c][s]) return 1'b0;
    for (int i = 0; i < slot_len[c][s]; i++) begin
      m = byte_at(slot_mask[c][s], i);
      if ((view[VIEW_W-1-BYTE_W*i -: BYTE_W] & m) != (byte_at(slot_pat[c][s], i) & m))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t run_command(beat_t b);
    verdict_t           v;
    int                 c;
    int                 cnt;
    int                 n;
    int                 pn;
    int                 vlen;
    int                 last;
    logic [BYTES_W-1:0] keep;
    logic [VIEW_W-1:0]  view;
    logic               seen_pass;
    logic               pass_hit;
    logic               blocked;
    logic               hit;
    c = int'(b.channel);
    cnt = slot_count[c];
    v.status = STATUS_OK;
    v.assigned_id = '0;
    v.frame_passes = 1'b0;
    case (b.command)
      CMD_ADD: begin
        if (cnt >= SLOTS) begin
          v.status = STATUS_FULL;
        end else begin
          n = clip_len(b.mask_length);
          pn = clip_len(b.pattern_length);
          if (pn > n) pn = n;
          keep = '1;
          keep = (pn == 0) ? '0 : keep << (BYTES_W - BYTE_W * pn);
          slot_id[c][cnt] = id_next[c];
          slot_block[c][cnt] = b.filter_kind;
          slot_len[c][cnt] = n;
          slot_mask[c][cnt] = b.mask_bytes;
          slot_pat[c][cnt] = b.pattern_bytes & keep;
          slot_count[c] = cnt + 1;
          v.assigned_id = id_next[c];
          id_next[c] = id_next[c] + 1'b1;
        end
      end
      CMD_STOP: begin
        v.status = STATUS_NO_ID;
        last = cnt - 1;
        for (int i = 0; i < cnt; i++) begin
          if (slot_id[c][i] == b.target_filter) begin
            slot_id[c][i] = slot_id[c][last];
            slot_block[c][i] = slot_block[c][last];
            slot_mask[c][i] = slot_mask[c][last];
            slot_pat[c][i] = slot_pat[c][last];
            slot_len[c][i] = slot_len[c][last];
            slot_count[c] = last;
            v.status = STATUS_OK;
            break;
          end
        end
      end
      CMD_CLEAR: begin
        slot_count[c] = 0;
      end
      default: begin
        view = {b.frame_id, b.frame_data};
        vlen = ID_BYTES + clip_len(b.frame_dlc);
        seen_pass = 1'b0;
        pass_hit = 1'b0;
        blocked = 1'b0;
        for (int i = 0; i < cnt; i++) begin
          hit = slot_hits(c, i, view, vlen);
          if (slot_block[c][i]) begin
            if (hit) begin
              blocked = 1'b1;
              break;
            end
          end else begin
            seen_pass = 1'b1;
            pass_hit = pass_hit | hit;
          end
        end
        v.frame_passes = !blocked && (!seen_pass || pass_hit);
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    beat_t    b;
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      for (int c = 0; c < LANES; c++) begin
        slot_count[c] = 0;
        id_next[c] = 1;
      end
      awaited.delete();
      error_tally = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        b.command = cmd_t'(in_ch.command);
        b.channel = in_ch.channel;
        b.filter_kind = in_ch.filter_kind;
        b.mask_bytes = in_ch.mask_bytes;
        b.mask_length = in_ch.mask_length;
        b.pattern_bytes = in_ch.pattern_bytes;
        b.pattern_length = in_ch.pattern_length;
        b.target_filter = in_ch.target_filter;
        b.frame_id = in_ch.frame_id;
        b.frame_data = in_ch.frame_data;
        b.frame_dlc = in_ch.frame_dlc;
        awaited.push_back(run_command(b));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.assigned_id = out_ch.assigned_id;
        got.frame_passes = out_ch.frame_passes;
        if (awaited.size() == 0) begin
          error_tally++;
          if (error_tally <= 10)
            $display("unexpected result beat: status %0d id %0h passes %0b",
                     got.status, got.assigned_id, got.frame_passes);
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            error_tally++;
            if (error_tally <= 10)
              $display("mismatch: expected status %0d id %0h passes %0b, got %0d %0h %0b",
                       want.status, want.assigned_id, want.frame_passes,
                       got.status, got.assigned_id, got.frame_passes);
          end
        end
      end
    end
    mismatches <= error_tally;
    outstanding <= awaited.size();
  end

endmodule

// ----- test/can_pass_block_filter_table_test.sv -----
// Testbench top for the filter table: clock, reset, command stimulus and verdict.
module can_pass_block_filter_table_test;
  import cpbft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_t               command;
    logic               channel;
    logic               filter_kind;
    logic [BYTES_W-1:0] mask_bytes;
    logic [LEN_W-1:0]   mask_length;
    logic [BYTES_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]   pattern_length;
    logic [ID_W-1:0]    target_filter;
    logic [ID_W-1:0]    frame_id;
    logic [BYTES_W-1:0] frame_data;
    logic [LEN_W-1:0]   frame_dlc;
  } order_t;

  logic clk;
  logic rst_n;
  logic gaps_on;
  int   mismatches;
  int   outstanding;
  int   tally [4];

  logic [ID_W-1:0]    live_ids [DEF_NUM_CHANNELS][$];
  logic [ID_W-1:0]    next_issue [DEF_NUM_CHANNELS];
  logic [BYTES_W-1:0] last_pattern [DEF_NUM_CHANNELS];

  cpbft_in_if  in_if ();
  cpbft_out_if out_if ();

  can_pass_block_filter_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  cpbft_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("can_pass_block_filter_table_test failed");
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= !(gaps_on && $urandom_range(0, 99) < 26);
    end
  end

  function automatic order_t scramble(cmd_t c, logic ch);
    order_t o;
    o.command = c;
    o.channel = ch;
    o.filter_kind = 1'($urandom);
    o.mask_bytes = {$urandom, $urandom};
    o.mask_length = 4'($urandom);
    o.pattern_bytes = {$urandom, $urandom};
    o.pattern_length = 4'($urandom);
    o.target_filter = $urandom;
    o.frame_id = $urandom;
    o.frame_data = {$urandom, $urandom};
    o.frame_dlc = 4'($urandom);
    return o;
  endfunction

  function automatic logic [BYTES_W-1:0] sparse_word();
    logic [BYTES_W-1:0] w;
    for (int i = 0; i < FILTER_BYTES; i++) begin
      case ($urandom_range(0, 4))
        0, 1:    w[BYTE_W*i +: BYTE_W] = 8'h00;
        2, 3:    w[BYTE_W*i +: BYTE_W] = 8'hFF;
        default: w[BYTE_W*i +: BYTE_W] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic logic [LEN_W-1:0] short_len();
    return ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
  endfunction

  task automatic issue(order_t o);
    int ch;
    ch = int'(o.channel);
    if (gaps_on && $urandom_range(0, 99) < 26) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= o.command;
    in_if.channel <= o.channel;
    in_if.filter_kind <= o.filter_kind;
    in_if.mask_bytes <= o.mask_bytes;
    in_if.mask_length <= o.mask_length;
    in_if.pattern_bytes <= o.pattern_bytes;
    in_if.pattern_length <= o.pattern_length;
    in_if.target_filter <= o.target_filter;
    in_if.frame_id <= o.frame_id;
    in_if.frame_data <= o.frame_data;
    in_if.frame_dlc <= o.frame_dlc;
    do @(posedge clk); while (!in_if.ready);
    tally[int'(o.command)]++;
    case (o.command)
      CMD_ADD: begin
        if (live_ids[ch].size() < DEF_MAX_FILTERS) begin
          live_ids[ch].push_back(next_issue[ch]);
          next_issue[ch] = next_issue[ch] + 1'b1;
        end
      end
      CMD_STOP: begin
        for (int i = 0; i < live_ids[ch].size(); i++) begin
          if (live_ids[ch][i] == o.target_filter) begin
            live_ids[ch].delete(i);
            break;
          end
        end
      end
      CMD_CLEAR: live_ids[ch].delete();
      default: ;
    endcase
  endtask

  initial begin
    order_t o;
    int     r;
    int     c;
    gaps_on = 1'b1;
    for (int i = 0; i < 4; i++) tally[i] = 0;
    for (int i = 0; i < DEF_NUM_CHANNELS; i++) begin
      next_issue[i] = 1;
      last_pattern[i] = '0;
    end
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= CMD_ADD;
    in_if.channel <= 1'b0;
    in_if.filter_kind <= 1'b0;
    in_if.mask_bytes <= '0;
    in_if.mask_length <= '0;
    in_if.pattern_bytes <= '0;
    in_if.pattern_length <= '0;
    in_if.target_filter <= '0;
    in_if.frame_id <= '0;
    in_if.frame_data <= '0;
    in_if.frame_dlc <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: check passes, stop finds nothing
    o = scramble(CMD_CHECK, 1'b0);
    issue(o);
    o = scramble(CMD_STOP, 1'b0);
    o.target_filter = 32'hFFFF_FFFF;
    issue(o);
    // zero-length pass filter matches everything
    o = scramble(CMD_ADD, 1'b0);
    o.filter_kind = 1'b0;
    o.mask_length = 4'd0;
    issue(o);
    // block filter, all-ones mask and pattern, lengths above eight
    o = scramble(CMD_ADD, 1'b0);
    o.filter_kind = 1'b1;
    o.mask_bytes = '1;
    o.mask_length = 4'hF;
    o.pattern_bytes = '1;
    o.pattern_length = 4'hF;
    issue(o);
    o = scramble(CMD_CHECK, 1'b0);
    o.frame_id = '1;
    o.frame_data = '1;
    o.frame_dlc = 4'hF;
    issue(o);
    o.frame_dlc = 4'd0;
    issue(o);
    o.frame_id = '0;
    o.frame_data = '0;
    o.frame_dlc = 4'd8;
    issue(o);
    // short pattern, then pattern longer than mask
    o = scramble(CMD_ADD, 1'b0);
    o.filter_kind = 1'b0;
    o.mask_bytes = '1;
    o.mask_length = 4'd6;
    o.pattern_bytes = '1;
    o.pattern_length = 4'd2;
    issue(o);
    o.mask_length = 4'd3;
    o.pattern_length = 4'd9;
    issue(o);
    o = scramble(CMD_CHECK, 1'b0);
    o.frame_id = 32'hFFFF_0000;
    o.frame_data = '0;
    o.frame_dlc = 4'd2;
    issue(o);
    // fill the table; the last add finds it full
    repeat (5) begin
      o = scramble(CMD_ADD, 1'b0);
      issue(o);
    end
    o = scramble(CMD_STOP, 1'b0);
    o.target_filter = 32'd2;
    issue(o);
    o.target_filter = live_ids[0][$];
    issue(o);
    o.target_filter = 32'd0;
    issue(o);
    o = scramble(CMD_CHECK, 1'b0);
    issue(o);
    o = scramble(CMD_CLEAR, 1'b0);
    issue(o);
    o = scramble(CMD_CHECK, 1'b0);
    issue(o);
    // second channel: zero-mask block filter of full length
    o = scramble(CMD_ADD, 1'b1);
    o.filter_kind = 1'b1;
    o.mask_bytes = '0;
    o.mask_length = 4'd8;
    issue(o);
    o = scramble(CMD_CHECK, 1'b1);
    o.frame_dlc = 4'd3;
    issue(o);
    o.frame_dlc = 4'd4;
    issue(o);
    o = scramble(CMD_CLEAR, 1'b1);
    issue(o);

    for (int k = 0; k < 600; k++) begin
      gaps_on = !(k >= 250 && k < 400);
      r = $urandom_range(0, 99);
      c = $urandom_range(0, 1);
      if (r < 35) begin
        o = scramble(CMD_ADD, 1'(c));
        o.mask_bytes = sparse_word();
        o.mask_length = short_len();
        o.pattern_bytes = sparse_word();
        o.pattern_length = short_len();
        last_pattern[c] = o.pattern_bytes;
      end else if (r < 55) begin
        o = scramble(CMD_STOP, 1'(c));
        if (live_ids[c].size() != 0 && $urandom_range(0, 3) != 0)
          o.target_filter = live_ids[c][$urandom_range(0, live_ids[c].size() - 1)];
        else if ($urandom_range(0, 1) == 0)
          o.target_filter = next_issue[c];
      end else if (r < 60) begin
        o = scramble(CMD_CLEAR, 1'(c));
      end else if (r < 95) begin
        o = scramble(CMD_CHECK, 1'(c));
        o.frame_id = ID_W'(sparse_word());
        o.frame_data = sparse_word();
        if ($urandom_range(0, 1) == 0) begin
          o.frame_id = last_pattern[c][63:32];
          o.frame_data[63:32] = last_pattern[c][31:0];
        end
        o.frame_dlc = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(4, 8));
      end else begin
        o = scramble(cmd_t'(2'($urandom)), 1'(c));
      end
      issue(o);
    end
    in_if.valid <= 1'b0;
    gaps_on = 1'b1;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d adds, %0d stops, %0d clears and %0d frame checks on both channels,",
             tally[int'(CMD_ADD)], tally[int'(CMD_STOP)], tally[int'(CMD_CLEAR)],
             tally[int'(CMD_CHECK)]);
    $display("including full tables, unknown ids and stretches with and without stalls");
    if (mismatches == 0 && outstanding == 0) begin
      $display("can_pass_block_filter_table_test passed");
    end else begin
      $display("can_pass_block_filter_table_test failed");
    end
    $finish;
  end

endmodule

// ----- can_pass_block_filter_table.f -----
design/cpbft_pkg.sv
design/cpbft_ifs.sv
design/cpbft_front.sv
design/cpbft_queue.sv
design/cpbft_back.sv
design/can_pass_block_filter_table.sv
test/cpbft_checker.sv
test/can_pass_block_filter_table_test.sv
